// ===== sv/bmpb_pkg.sv =====
package bmpb_pkg;

    // pixel format codes, code 3 behaves as 32-bit BGRA
    localparam logic [1:0] FMT_RGB565 = 2'd0;
    localparam logic [1:0] FMT_BGR24  = 2'd1;
    localparam logic [1:0] FMT_BGRA32 = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_WIDTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND    = 2'd3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam int unsigned WIDTH_W     = 12;
    localparam int unsigned ROW_BYTES_W = 14;

    localparam logic [1:0]         RESET_FORMAT        = FMT_BGR24;
    localparam logic [WIDTH_W-1:0] RESET_IMAGE_WIDTH   = 12'd320;
    localparam logic [WIDTH_W-1:0] RESET_DISPLAY_WIDTH = 12'd320;
    localparam logic [15:0]        RESET_BACKGROUND    = 16'h0000;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;
    localparam int unsigned QUEUE_CNT_W = 3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef struct packed {
        logic [1:0]         pixel_format;
        logic [WIDTH_W-1:0] image_width;
        logic [WIDTH_W-1:0] display_width;
        logic [15:0]        background;
    } cfg_t;

    // what the back end does with a pixel
    typedef enum logic [1:0] {
        KIND_PASS565,
        KIND_PACK,
        KIND_BGFILL,
        KIND_BLEND
    } pix_kind_t;

    // word holds b0 in bits 7..0 up to alpha in bits 31..24
    typedef struct packed {
        pix_kind_t   kind;
        logic        row_last;
        logic [31:0] word;
    } entry_t;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // signed (px - bg) * alpha, magnitude at most 255 * 255
    function automatic logic signed [17:0] blend_mult(input logic [7:0] px,
                                                      input logic [7:0] bgc,
                                                      input logic [7:0] alpha);
        logic signed [8:0] diff;
        diff = $signed({1'b0, px}) - $signed({1'b0, bgc});
        return diff * $signed({1'b0, alpha});
    endfunction

    // product / 255 toward zero, plus background, modulo 256
    // floor(m / 255) = (m + (m >> 8) + 1) >> 8 holds for m below 255 * 255
    function automatic logic [7:0] blend_finish(input logic signed [17:0] prod,
                                                input logic [7:0] bgc);
        logic        neg;
        logic [17:0] mag_wide;
        logic [15:0] mag;
        logic [16:0] sum;
        logic [7:0]  quo;
        neg      = prod[17];
        mag_wide = neg ? 18'(-prod) : 18'(prod);
        mag      = mag_wide[15:0];
        sum      = {1'b0, mag} + {9'b0, mag[15:8]} + 17'd1;
        quo      = sum[15:8];
        return neg ? 8'(bgc - quo) : 8'(bgc + quo);
    endfunction

endpackage

// ===== sv/bmpb_front.sv =====
module bmpb_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bmpb_pkg::cfg_t       cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 queue_full,
    output logic                 push,
    output bmpb_pkg::entry_t     push_entry
);

    logic [1:0]                        byte_in_pixel_reg, byte_in_pixel_next;
    logic [bmpb_pkg::ROW_BYTES_W-1:0]  pixel_column_reg, pixel_column_next;
    logic [bmpb_pkg::ROW_BYTES_W-1:0]  row_byte_count_reg, row_byte_count_next;
    logic [23:0]                       held_bytes_reg, held_bytes_next;

    logic [2:0]                        nbytes;
    logic [bmpb_pkg::ROW_BYTES_W-1:0]  pix_bytes;
    logic [bmpb_pkg::ROW_BYTES_W-1:0]  padded;
    logic [bmpb_pkg::ROW_BYTES_W-1:0]  count_inc;
    logic [bmpb_pkg::WIDTH_W-1:0]      iw, dw, start, keep;
    // column can run past the image width after a format change mid-row
    logic [bmpb_pkg::ROW_BYTES_W-1:0]  offset, start_ext, keep_ext;
    logic [31:0]                       top_byte, word;
    logic                              accept, in_pixel, complete, visible;
    bmpb_pkg::pix_kind_t               kind;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign iw      = cfg.image_width;
    assign dw      = cfg.display_width;

    // row geometry
    always_comb begin
        case (cfg.pixel_format)
            bmpb_pkg::FMT_RGB565: begin
                nbytes    = 3'd2;
                pix_bytes = bmpb_pkg::ROW_BYTES_W'({iw, 1'b0});
                top_byte  = {16'b0, s_data_byte, 8'b0};
            end
            bmpb_pkg::FMT_BGR24: begin
                nbytes    = 3'd3;
                pix_bytes = bmpb_pkg::ROW_BYTES_W'({iw, 1'b0}) + bmpb_pkg::ROW_BYTES_W'(iw);
                top_byte  = {8'b0, s_data_byte, 16'b0};
            end
            default: begin
                nbytes    = 3'd4;
                pix_bytes = bmpb_pkg::ROW_BYTES_W'({iw, 2'b00});
                top_byte  = {s_data_byte, 24'b0};
            end
        endcase
    end

    assign padded    = (pix_bytes + bmpb_pkg::ROW_BYTES_W'(3)) & ~bmpb_pkg::ROW_BYTES_W'(3);
    assign start     = (iw > dw) ? ((iw - dw) >> 1) : '0;
    assign keep      = (iw > dw) ? dw : iw;
    assign start_ext = bmpb_pkg::ROW_BYTES_W'(start);
    assign keep_ext  = bmpb_pkg::ROW_BYTES_W'(keep);
    assign offset    = pixel_column_reg - start_ext;
    assign visible   = (pixel_column_reg >= start_ext) && (offset < keep_ext);
    assign in_pixel  = row_byte_count_reg < pix_bytes;
    assign complete  = in_pixel && ({1'b0, byte_in_pixel_reg} >= (nbytes - 3'd1));
    assign word      = {8'b0, held_bytes_reg} | top_byte;
    assign count_inc = row_byte_count_reg + bmpb_pkg::ROW_BYTES_W'(1);

    // classify the finished pixel
    always_comb begin
        if (nbytes == 3'd2) begin
            kind = bmpb_pkg::KIND_PASS565;
        end else if (nbytes == 3'd3 || word[31:24] == bmpb_pkg::ALPHA_OPAQUE) begin
            kind = bmpb_pkg::KIND_PACK;
        end else if (word[31:24] == bmpb_pkg::ALPHA_CLEAR) begin
            kind = bmpb_pkg::KIND_BGFILL;
        end else begin
            kind = bmpb_pkg::KIND_BLEND;
        end
    end

    assign push                = accept && complete && visible;
    assign push_entry.kind     = kind;
    assign push_entry.row_last = (offset == keep_ext - bmpb_pkg::ROW_BYTES_W'(1));
    assign push_entry.word     = word;

    always_comb begin
        byte_in_pixel_next  = byte_in_pixel_reg;
        pixel_column_next   = pixel_column_reg;
        row_byte_count_next = row_byte_count_reg;
        held_bytes_next     = held_bytes_reg;
        if (accept) begin
            if (in_pixel) begin
                if (complete) begin
                    pixel_column_next  = pixel_column_reg + bmpb_pkg::ROW_BYTES_W'(1);
                    byte_in_pixel_next = '0;
                    held_bytes_next    = '0;
                end else begin
                    held_bytes_next    = held_bytes_reg
                                       | (24'(s_data_byte) << {byte_in_pixel_reg, 3'b000});
                    byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
                end
            end
            row_byte_count_next = count_inc;
            // end of padded row
            if (count_inc >= padded) begin
                byte_in_pixel_next  = '0;
                pixel_column_next   = '0;
                row_byte_count_next = '0;
                held_bytes_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_in_pixel_reg  <= '0;
            pixel_column_reg   <= '0;
            row_byte_count_reg <= '0;
            held_bytes_reg     <= '0;
        end else begin
            byte_in_pixel_reg  <= byte_in_pixel_next;
            pixel_column_reg   <= pixel_column_next;
            row_byte_count_reg <= row_byte_count_next;
            held_bytes_reg     <= held_bytes_next;
        end
    end

endmodule

// ===== sv/bmpb_queue.sv =====
module bmpb_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bmpb_pkg::entry_t    push_entry,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output bmpb_pkg::entry_t    head_entry
);

    bmpb_pkg::entry_t                  slot_reg [bmpb_pkg::QUEUE_DEPTH];
    logic [bmpb_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bmpb_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bmpb_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == bmpb_pkg::QUEUE_CNT_W'(bmpb_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bmpb_pkg::QUEUE_CNT_W'(bmpb_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a write");
`endif

endmodule

// ===== sv/bmpb_back.sv =====
module bmpb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         background,
    input  logic                head_valid,
    input  bmpb_pkg::entry_t    head_entry,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_pixel_rgb565,
    output logic                m_row_last
);

    logic                    s1_valid_reg;
    logic                    s1_blend_reg;
    logic                    s1_last_reg;
    logic [15:0]             s1_pix_reg;
    logic signed [17:0]      s1_prod_reg [3];
    logic [7:0]              s1_bgc_reg [3];

    logic                    out_valid_reg;
    logic [15:0]             out_pix_reg;
    logic                    out_last_reg;

    logic                    out_en, s1_en;
    logic [7:0]              bgc [3];
    logic [7:0]              pxc [3];
    logic [15:0]             direct_pix;
    logic [15:0]             blend_pix;

    assign out_en = !out_valid_reg || m_ready;
    assign s1_en  = !s1_valid_reg || out_en;
    assign pop    = head_valid && s1_en;

    // background channels, zero filled to 8 bits; index 0 red, 1 green, 2 blue
    assign bgc[0] = {background[15:11], 3'b000};
    assign bgc[1] = {background[10:5], 2'b00};
    assign bgc[2] = {background[4:0], 3'b000};
    assign pxc[0] = head_entry.word[23:16];
    assign pxc[1] = head_entry.word[15:8];
    assign pxc[2] = head_entry.word[7:0];

    always_comb begin
        case (head_entry.kind)
            bmpb_pkg::KIND_PASS565: direct_pix = head_entry.word[15:0];
            bmpb_pkg::KIND_PACK:    direct_pix = bmpb_pkg::pack565(pxc[0], pxc[1], pxc[2]);
            bmpb_pkg::KIND_BGFILL:  direct_pix = background;
            default:                direct_pix = '0;
        endcase
    end

    // stage 1: per-channel products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_blend_reg <= (head_entry.kind == bmpb_pkg::KIND_BLEND);
            s1_last_reg  <= head_entry.row_last;
            s1_pix_reg   <= direct_pix;
            for (int c = 0; c < 3; c++) begin
                s1_prod_reg[c] <= bmpb_pkg::blend_mult(pxc[c], bgc[c], head_entry.word[31:24]);
                s1_bgc_reg[c]  <= bgc[c];
            end
        end
    end

    // stage 2: divide by 255, add background, pack
    assign blend_pix = bmpb_pkg::pack565(bmpb_pkg::blend_finish(s1_prod_reg[0], s1_bgc_reg[0]),
                                         bmpb_pkg::blend_finish(s1_prod_reg[1], s1_bgc_reg[1]),
                                         bmpb_pkg::blend_finish(s1_prod_reg[2], s1_bgc_reg[2]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            out_pix_reg  <= s1_blend_reg ? blend_pix : s1_pix_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_pixel_rgb565 = out_pix_reg;
    assign m_row_last     = out_last_reg;

endmodule

// ===== sv/bmp_row_to_rgb565_blend_top.sv =====
// a finished pixel passes the queue, the stage 1 register and the output register
// throughput: a byte per cycle while the queue has room; a result per 2, 3 or 4 bytes
// the four-entry queue between byte front end and blend pipeline absorbs output stalls
// reset (aresetn low, synchronous): format BGR 24 bit, widths 320, background 0,
// row counters cleared, queue and pipeline emptied
module bmp_row_to_rgb565_blend_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bmpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bmpb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // bitmap byte stream
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    // rgb565 pixels
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [15:0]                        m_pixel_rgb565,
    output logic                               m_row_last
);

    bmpb_pkg::cfg_t     cfg_reg, cfg_next;
    logic               push, pop, queue_full, head_valid;
    bmpb_pkg::entry_t   push_entry, head_entry;

    // register writes are always accepted and registered in cfg_reg
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bmpb_pkg::CFG_PIXEL_FORMAT:  cfg_next.pixel_format  = cfg_data[1:0];
                bmpb_pkg::CFG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[11:0];
                bmpb_pkg::CFG_DISPLAY_WIDTH: cfg_next.display_width = cfg_data[11:0];
                bmpb_pkg::CFG_BACKGROUND:    cfg_next.background    = cfg_data[15:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format  <= bmpb_pkg::RESET_FORMAT;
            cfg_reg.image_width   <= bmpb_pkg::RESET_IMAGE_WIDTH;
            cfg_reg.display_width <= bmpb_pkg::RESET_DISPLAY_WIDTH;
            cfg_reg.background    <= bmpb_pkg::RESET_BACKGROUND;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: byte counting, pixel assembly, cropping and classification
    bmpb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .queue_full  (queue_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // short queue of classified pixels
    bmpb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // back end: two-stage blend and pack with output register
    bmpb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .background     (cfg_reg.background),
        .head_valid     (head_valid),
        .head_entry     (head_entry),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_rgb565 (m_pixel_rgb565),
        .m_row_last     (m_row_last)
    );

endmodule

// ===== dv/tb_bmp_row_to_rgb565_blend_top.sv =====
`timescale 1ns / 1ps

module tb_bmp_row_to_rgb565_blend_top;

    import bmpb_pkg::*;

    // format code 3 has no name in the package, the block treats it as 32-bit bgra
    localparam logic [1:0] FMT_BGRA32_ALT = 2'd3;

    localparam int unsigned RANDOM_ITEMS  = 650;
    localparam int unsigned QUIET_ITEMS   = 120;  // tail of the run with no idling
    localparam int unsigned SETTLE_CYCLES = 8;    // two-stage back end plus margin
    localparam int unsigned HOLD_CYCLES   = 80;   // long receiver hold-off
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // one row of the directed stimulus table
    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  addr;
        logic [15:0]             value;   // register data, or the byte in bits 7..0
        bit                      known;   // result given here instead of predicted
        logic [15:0]             pix;
        logic                    last;
    } dir_row_t;

    typedef struct {
        logic [15:0] pix;
        logic        last;
    } px_want_t;

    localparam int N_DIR = 39;

    // directed part: extremes, every format, alpha cases, cropping and
    // register writes in the middle of a row and of a pixel
    dir_row_t dir_tab [N_DIR] = '{
        // reset settings: bgr 24 bit, 320 wide, all-ones pixel
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h00FF, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h00FF, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h00FF, 1'b1, 16'hFFFF, 1'b0},
        // two bytes of the next pixel, then switch to rgb565 mid-pixel
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,  CFG_PIXEL_FORMAT, 16'(FMT_RGB565), 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,  CFG_IMAGE_WIDTH,  16'd4, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,  CFG_DISPLAY_WIDTH, 16'd1, 1'b0, 16'h0000, 1'b0},
        // completes the pixel early, then cropped out column
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h00AA, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0011, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0022, 1'b0, 16'h0000, 1'b0},
        // bgra, one pixel rows, white background
        '{ROW_CFG,  CFG_PIXEL_FORMAT, 16'(FMT_BGRA32), 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,  CFG_IMAGE_WIDTH,  16'd1, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,  CFG_DISPLAY_WIDTH, 16'd1, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,  CFG_BACKGROUND,   16'hFFFF, 1'b0, 16'h0000, 1'b0},
        // transparent pixel gives the background
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0000, 1'b1, 16'hFFFF, 1'b1},
        // opaque pixel passes the color
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0012, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0034, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0056, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h00FF, 1'b1, 16'h51A2, 1'b1},
        // half alpha blend
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h00FF, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0080, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0080, 1'b0, 16'h0000, 1'b0},
        // format code 3, mid-gray background, near-zero alpha
        '{ROW_CFG,  CFG_PIXEL_FORMAT, 16'(FMT_BGRA32_ALT), 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,  CFG_BACKGROUND,   16'h8410, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h00FF, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h007F, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h0001, 1'b0, 16'h0000, 1'b0},
        // zero-width image: every byte is padding
        '{ROW_CFG,  CFG_IMAGE_WIDTH,  16'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h005A, 1'b0, 16'h0000, 1'b0},
        // zero-width display: nothing visible
        '{ROW_CFG,  CFG_IMAGE_WIDTH,  16'd2, 1'b0, 16'h0000, 1'b0},
        '{ROW_CFG,  CFG_DISPLAY_WIDTH, 16'd0, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h00A5, 1'b0, 16'h0000, 1'b0},
        '{ROW_BYTE, CFG_PIXEL_FORMAT, 16'h003C, 1'b0, 16'h0000, 1'b0}
    };

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    cfg_valid   = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   cfg_data    = '0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_data_byte = 8'h00;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic [15:0]             m_pixel_rgb565;
    logic                    m_row_last;

    // predictor copy of the registers
    logic [1:0]        cur_fmt;
    logic [11:0]       cur_img_w;
    logic [11:0]       cur_disp_w;
    logic [15:0]       cur_bg;

    // predictor copy of the row state
    int unsigned       pos_in_pix;
    int unsigned       col;
    int unsigned       row_pos;
    logic [23:0]       held;

    px_want_t          pending_px [$];

    int unsigned       n_errors   = 0;
    int unsigned       cycle_cnt  = 0;
    int unsigned       bytes_sent = 0;

    // knobs shared between the sender and the receiver
    int unsigned       gap_pct    = 0;
    int unsigned       stall_pct  = 0;
    bit                calm       = 1'b0;
    bit                hold_req   = 1'b0;

    bmp_row_to_rgb565_blend_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_rgb565 (m_pixel_rgb565),
        .m_row_last     (m_row_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        n_errors++;
    endtask

    // --------------------------------------------------------------------
    // predictor
    // --------------------------------------------------------------------

    function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // (px - bg) * alpha / 255 + bg, division truncating toward zero, mod 256
    function automatic logic [7:0] blend_chan(input logic [7:0] bgc, input logic [7:0] px,
                                              input logic [7:0] a);
        int diff;
        int v;
        diff = int'(px) - int'(bgc);
        v    = (diff * int'(a)) / 255 + int'(bgc);
        return 8'(v);
    endfunction

    task automatic reset_predictor();
        cur_fmt    = FMT_BGR24;
        cur_img_w  = 12'd320;
        cur_disp_w = 12'd320;
        cur_bg     = 16'h0000;
        pos_in_pix = 0;
        col        = 0;
        row_pos    = 0;
        held       = '0;
    endtask

    // advances the row state by one byte, returns 1 when a visible pixel completes
    function automatic bit convert_byte(input logic [7:0] d, output logic [15:0] pix,
                                        output logic last);
        int unsigned bpp;
        int unsigned pix_bytes;
        int unsigned padded;
        int unsigned start;
        int unsigned keep;
        logic [31:0] word;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  a;
        bit          hit;
        hit  = 1'b0;
        pix  = '0;
        last = 1'b0;
        bpp  = (cur_fmt == FMT_RGB565) ? 2 : (cur_fmt == FMT_BGR24) ? 3 : 4;
        pix_bytes = cur_img_w * bpp;
        padded    = (pix_bytes + 3) & ~32'd3;
        start = 0;
        keep  = cur_img_w;
        // centered crop when the image is wider than the display
        if (cur_img_w > cur_disp_w) begin
            start = (cur_img_w - cur_disp_w) / 2;
            keep  = cur_disp_w;
        end
        if (row_pos < pix_bytes) begin
            if (pos_in_pix >= bpp - 1) begin
                word = {8'h00, held} | (32'(d) << (8 * (bpp - 1)));
                if (col >= start && col - start < keep) begin
                    hit = 1'b1;
                    b0  = word[7:0];
                    b1  = word[15:8];
                    b2  = word[23:16];
                    a   = word[31:24];
                    if (bpp == 2)
                        pix = word[15:0];
                    else if (bpp == 3 || a == ALPHA_OPAQUE)
                        pix = to565(b2, b1, b0);
                    else if (a == ALPHA_CLEAR)
                        pix = cur_bg;
                    else
                        pix = to565(blend_chan({cur_bg[15:11], 3'b000}, b2, a),
                                    blend_chan({cur_bg[10:5], 2'b00}, b1, a),
                                    blend_chan({cur_bg[4:0], 3'b000}, b0, a));
                    last = (col - start == keep - 1);
                end
                col        = col + 1;
                pos_in_pix = 0;
                held       = '0;
            end else begin
                held       = held | (24'(d) << (8 * pos_in_pix));
                pos_in_pix = pos_in_pix + 1;
            end
        end
        // padding bytes only move the row position
        row_pos = row_pos + 1;
        if (row_pos >= padded) begin
            pos_in_pix = 0;
            col        = 0;
            row_pos    = 0;
            held       = '0;
        end
        return hit;
    endfunction

    // --------------------------------------------------------------------
    // sender side
    // --------------------------------------------------------------------

    // one register write; valid is left high, the next byte or a drain lowers it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_PIXEL_FORMAT:  cur_fmt    = v[1:0];
            CFG_IMAGE_WIDTH:   cur_img_w  = v[11:0];
            CFG_DISPLAY_WIDTH: cur_disp_w = v[11:0];
            CFG_BACKGROUND:    cur_bg     = v;
            default: ;
        endcase
    endtask

    // one byte transfer; known rows carry their own expected pixel
    task automatic send_byte(input logic [7:0] d, input bit known,
                             input logic [15:0] kpix, input logic klast);
        logic [15:0] pix;
        logic        last;
        bit          hit;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        s_valid     <= 1'b1;
        s_data_byte <= d;
        do @(posedge aclk); while (!s_ready);
        hit = convert_byte(d, pix, last);
        if (known)
            pending_px.push_back('{kpix, klast});
        else if (hit)
            pending_px.push_back('{pix, last});
        bytes_sent++;
        // random idle burst after the transfer
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // stop sending, let every pixel out and the back end settle
    task automatic drain();
        s_valid <= 1'b0;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int unsigned iw;
        int unsigned dw;
        int unsigned bpp;
        int unsigned row_len;
        int unsigned nbytes;
        int unsigned rand_base;
        int unsigned phase;
        int          mode;
        logic [1:0]  fmt;
        logic [15:0] bg;
        logic [7:0]  d;
        bit          prev_byte;

        reset_predictor();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        gap_pct   = 30;
        stall_pct = 30;
        prev_byte = 1'b0;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                if (prev_byte)
                    drain();
                write_reg(dir_tab[i].addr, dir_tab[i].value);
                prev_byte = 1'b0;
            end else begin
                send_byte(dir_tab[i].value[7:0], dir_tab[i].known,
                          dir_tab[i].pix, dir_tab[i].last);
                prev_byte = 1'b1;
            end
        end

        // random phases: new settings, then mostly whole rows
        rand_base = bytes_sent;
        phase     = 0;
        while (bytes_sent - rand_base < RANDOM_ITEMS) begin
            drain();
            mode = $urandom_range(0, 9);
            fmt  = 2'($urandom_range(0, 3));
            if (phase == 0) begin
                // many small pixels against a long receiver hold-off
                fmt = FMT_RGB565;
                iw  = 8;
                dw  = 8;
            end else if (mode == 0) begin
                // widest image, only the start of a row
                iw = 4095;
                case ($urandom_range(0, 2))
                    0:       dw = 4095;
                    1:       dw = 4094;
                    default: dw = 1;
                endcase
            end else if (mode == 1) begin
                // zero widths and tiny rows
                iw = $urandom_range(0, 3);
                dw = $urandom_range(0, 3);
            end else begin
                iw = $urandom_range(1, 12);
                dw = ($urandom_range(0, 4) == 0) ? 4095 : $urandom_range(1, 14);
            end
            case ($urandom_range(0, 3))
                0:       bg = 16'h0000;
                1:       bg = 16'hFFFF;
                default: bg = 16'($urandom);
            endcase

            // unused upper bits of the format and width writes are random
            write_reg(CFG_PIXEL_FORMAT, {14'($urandom), fmt});
            write_reg(CFG_IMAGE_WIDTH, {4'($urandom), 12'(iw)});
            write_reg(CFG_DISPLAY_WIDTH, {4'($urandom), 12'(dw)});
            write_reg(CFG_BACKGROUND, bg);

            if (phase == 0) begin
                gap_pct   = 0;
                stall_pct = 0;
                hold_req  = 1'b1;
            end else if (bytes_sent - rand_base > RANDOM_ITEMS - QUIET_ITEMS) begin
                gap_pct   = 0;
                stall_pct = 0;
                calm      = 1'b1;
            end else begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end

            bpp     = (fmt == FMT_RGB565) ? 2 : (fmt == FMT_BGR24) ? 3 : 4;
            row_len = (iw * bpp + 3) & ~32'd3;
            if (phase != 0 && mode == 0)
                nbytes = $urandom_range(20, 40);
            else if (row_len == 0)
                nbytes = $urandom_range(2, 6);
            else begin
                nbytes = row_len * ((phase == 0) ? 4 : $urandom_range(1, 4));
                // broken row: a partial row left for the next settings
                if ($urandom_range(0, 3) == 0)
                    nbytes = nbytes + $urandom_range(1, row_len);
            end

            for (int k = 0; k < nbytes; k++) begin
                // no idling on either side in the tail of the run
                if (bytes_sent - rand_base >= RANDOM_ITEMS - QUIET_ITEMS) begin
                    gap_pct   = 0;
                    stall_pct = 0;
                    calm      = 1'b1;
                end
                // alpha bytes lean toward the clear and opaque cases
                if (cur_fmt[1] && pos_in_pix == 3 && row_pos < cur_img_w * 4) begin
                    case ($urandom_range(0, 3))
                        0:       d = ALPHA_CLEAR;
                        1:       d = ALPHA_OPAQUE;
                        default: d = 8'($urandom_range(0, 255));
                    endcase
                end else begin
                    d = 8'($urandom_range(0, 255));
                end
                send_byte(d, 1'b0, 16'h0000, 1'b0);
            end
            phase++;
        end

        // wait for the last pixels, then let the pipeline settle
        s_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // --------------------------------------------------------------------
    // receiver side
    // --------------------------------------------------------------------

    // short random stalls, one long hold-off on request, none once calm
    initial begin : receiver
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // every pixel transfer is checked against the oldest expected pixel
    always @(posedge aclk) begin
        px_want_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_px.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel %h last %b",
                                          m_pixel_rgb565, m_row_last));
            end else begin
                want = pending_px.pop_front();
                if (m_pixel_rgb565 !== want.pix)
                    report_mismatch($sformatf("pixel %h, expected %h",
                                              m_pixel_rgb565, want.pix));
                if (m_row_last !== want.last)
                    report_mismatch($sformatf("row_last %b, expected %b on pixel %h",
                                              m_row_last, want.last, want.pix));
            end
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge aclk);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bmpb_pkg.sv
sv/bmpb_front.sv
sv/bmpb_queue.sv
sv/bmpb_back.sv
sv/bmp_row_to_rgb565_blend_top.sv
dv/tb_bmp_row_to_rgb565_blend_top.sv
